// ===== src/mbt_pkg.sv =====
`timescale 1ns / 1ps

package mbt_pkg;

  localparam int DEPTH  = 32;
  localparam int WORD_W = 32;
  localparam int FUNC_W = 2;
  localparam int OUT_W  = 6;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [FUNC_W-1:0] OP_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } mbt_state_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } mbt_cell_ctl_t;

endpackage

// ===== src/mbt_cell.sv =====
`timescale 1ns / 1ps

module mbt_cell (
  input  logic                        clk,
  input  mbt_pkg::mbt_cell_ctl_t      ctl,
  input  logic [mbt_pkg::WORD_W-1:0]  nbr_d,
  input  logic [mbt_pkg::WORD_W-1:0]  wr_d,
  output logic [mbt_pkg::WORD_W-1:0]  q
);
  import mbt_pkg::*;

  logic [WORD_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      q_r <= wr_d;
    end else if (ctl.shift) begin
      q_r <= nbr_d;
    end
  end

  assign q = q_r;

endmodule

// ===== src/multiset_bag_table_unit.sv =====
// Insert and unused codes go from ST_IDLE straight to ST_FIN, and the result word is
//   registered out of ST_FIN; erase and count pass through ST_SCAN before ST_FIN.
// start is taken only in ST_IDLE (busy low), so one word is in flight at a time; erase
//   and count rotate the whole cell ring once, one entry past the comparator per cycle.
// Reset (rst_n low, synchronous): fill level, control and result strobe clear;
//   stored words stay undefined until written. Results cannot be stalled.
`timescale 1ns / 1ps

module multiset_bag_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mbt_pkg::FUNC_W-1:0]        in_func,
  input  logic signed [mbt_pkg::WORD_W-1:0] in_value,
  output logic                              out_strobe,
  output logic                              out_ok,
  output logic [mbt_pkg::OUT_W-1:0]         out_matches_res,
  output logic [mbt_pkg::OUT_W-1:0]         out_fill_level
);
  import mbt_pkg::*;

  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(DEPTH - 1);

  mbt_state_t        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  hit_r, hit_nxt;
  logic [WORD_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              strobe_r, strobe_nxt;
  logic              ok_r, ok_nxt;
  logic [OUT_W-1:0]  matches_r, matches_nxt;
  logic [OUT_W-1:0]  fill_out_r, fill_out_nxt;

  logic              shift_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] cell_q [DEPTH];
  mbt_cell_ctl_t     cell_ctl [DEPTH];
  logic [WORD_W-1:0] head;
  logic              in_range;
  logic              is_last;

  assign head     = cell_q[0];
  assign in_range = CNT_W'(k_r) < fill_r;
  assign is_last  = (CNT_W'(k_r) + CNT_W'(1)) == fill_r;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign cell_ctl[gi].shift = shift_en;
      assign cell_ctl[gi].wr    = wr_en && (wr_idx == IDX_W'(gi));
      mbt_cell u_cell (
        .clk   (clk),
        .ctl   (cell_ctl[gi]),
        .nbr_d (cell_q[(gi + 1) % DEPTH]),
        .wr_d  (wr_data),
        .q     (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    val_r      <= val_nxt;
    k_r        <= k_nxt;
    hits_r     <= hits_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    last_r     <= last_nxt;
    ok_r       <= ok_nxt;
    matches_r  <= matches_nxt;
    fill_out_r <= fill_out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    val_nxt      = val_r;
    k_nxt        = k_r;
    hits_nxt     = hits_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    last_nxt     = last_r;
    fill_nxt     = fill_r;
    strobe_nxt   = 1'b0;
    ok_nxt       = ok_r;
    matches_nxt  = matches_r;
    fill_out_nxt = fill_out_r;
    shift_en     = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = '0;
    wr_data      = val_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          val_nxt   = unsigned'(in_value);
          k_nxt     = '0;
          hits_nxt  = '0;
          found_nxt = 1'b0;
          if (in_func == OP_ERASE || in_func == OP_COUNT) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        k_nxt    = k_r + IDX_W'(1);
        if (in_range && head == val_r) begin
          hits_nxt = hits_r + CNT_W'(1);
          if (!found_r) begin
            found_nxt = 1'b1;
            hit_nxt   = k_r;
          end
        end
        if (is_last) begin
          last_nxt = head;
        end
        if (k_r == K_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        strobe_nxt  = 1'b1;
        ok_nxt      = 1'b0;
        matches_nxt = '0;
        unique case (func_r)
          OP_INSERT: begin
            if (fill_r < CNT_W'(DEPTH)) begin
              wr_en    = 1'b1;
              wr_idx   = fill_r[IDX_W-1:0];
              wr_data  = val_r;
              fill_nxt = fill_r + CNT_W'(1);
              ok_nxt   = 1'b1;
            end
          end
          OP_ERASE: begin
            if (found_r) begin
              wr_en    = 1'b1;
              wr_idx   = hit_r;
              wr_data  = last_r;
              fill_nxt = fill_r - CNT_W'(1);
              ok_nxt   = 1'b1;
            end
          end
          OP_COUNT: begin
            ok_nxt      = 1'b1;
            matches_nxt = OUT_W'(hits_r);
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
        fill_out_nxt = OUT_W'(fill_nxt);
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_ok          = ok_r;
  assign out_matches_res = matches_r;
  assign out_fill_level  = fill_out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill level above capacity");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_matches_res != '0 |-> out_ok)
    else $error("nonzero match count without ok");

endmodule
